// ----- sv/gtr_pkg.sv -----
// shared types and constants of the gamepad turbo remapper
`timescale 1ns / 1ps

package gtr_pkg;

	localparam int NUM_PORTS   = 4;
	localparam int NUM_KEYS    = 24;
	localparam int NUM_BTN     = 16;
	localparam int NUM_TARGETS = 4;
	localparam int PORT_W      = 2;
	localparam int MASK_W      = 28;
	localparam int PHASE_W     = 8;
	localparam int IDX_W       = 5;
	localparam int POS_W       = 8;
	localparam int THR_W       = 7;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 8;

	localparam logic [MASK_W-1:0] KEY_MASK = 28'h0FFFFFFF;

	localparam logic [POS_W-1:0]   CENTER_RST = 8'd128;
	localparam logic [THR_W-1:0]   THRESH_RST = 7'd64;

	typedef enum logic {
		FUNC_POLL = 1'b0,
		FUNC_LOAD = 1'b1
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_REPEAT_GAP        = 2'd0,
		CFG_STICK_MID         = 2'd1,
		CFG_STICK_DEAD        = 2'd2,
		CFG_FIRST_PORT_TARGET = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		func_t              func;
		logic [PORT_W-1:0]  port;
		logic               frame_start;
		logic [NUM_BTN-1:0] buttons;
		logic [POS_W-1:0]   left_x;
		logic [POS_W-1:0]   left_y;
		logic [POS_W-1:0]   right_x;
		logic [POS_W-1:0]   right_y;
		logic [IDX_W-1:0]   entry_index;
		logic [MASK_W-1:0]  entry_mask;
		logic               entry_turbo;
	} req_t;

	typedef struct packed {
		logic [PORT_W-1:0] target_port;
		logic [MASK_W-1:0] port_keys;
	} rsp_t;

	typedef struct packed {
		logic [PHASE_W-1:0] repeat_gap;
		logic [POS_W-1:0]   stick_mid;
		logic [THR_W-1:0]   stick_dead;
		logic [PORT_W-1:0]  first_port_target;
	} cfg_t;

	// control of the merge stage for one accepted item
	typedef struct packed {
		logic              poll;
		logic              load;
		logic              port_ok;
		logic              frame_start;
		logic [PORT_W-1:0] port;
	} acc_ctl_t;

endpackage

// ----- sv/gtr_keydec.sv -----
// stick threshold decode and the buttons into the 24 local key bits
`timescale 1ns / 1ps

module gtr_keydec
	import gtr_pkg::*;
(
	input  req_t                req,
	input  cfg_t                cfg,
	output logic [NUM_KEYS-1:0] keys
);

	// bit 0 low side, bit 1 high side; bounds never wrap
	function automatic logic [1:0] axis_bits(input logic [POS_W-1:0] pos,
			input logic [POS_W-1:0] center, input logic [THR_W-1:0] thr);
		logic [POS_W:0] pos_plus;
		logic [POS_W:0] hi_bound;
		logic [1:0]     r;
		pos_plus = {1'b0, pos} + {{(POS_W+1-THR_W){1'b0}}, thr};
		hi_bound = {1'b0, center} + {{(POS_W+1-THR_W){1'b0}}, thr};
		r = 2'b00;
		if (pos_plus < {1'b0, center})
			r = 2'b01;
		else if ({1'b0, pos} > hi_bound)
			r = 2'b10;
		return r;
	endfunction

	logic [1:0] lx, ly, rx, ry;

	always_comb begin
		lx = axis_bits(req.left_x, cfg.stick_mid, cfg.stick_dead);
		ly = axis_bits(req.left_y, cfg.stick_mid, cfg.stick_dead);
		rx = axis_bits(req.right_x, cfg.stick_mid, cfg.stick_dead);
		ry = axis_bits(req.right_y, cfg.stick_mid, cfg.stick_dead);
		keys = {ry[1], rx[1], ry[0], rx[0], ly[1], lx[1], ly[0], lx[0], req.buttons};
	end

endmodule

// ----- sv/gtr_lane.sv -----
// one key lane: map entry, per-port turbo phase and press history
`timescale 1ns / 1ps

module gtr_lane
	import gtr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load_en,
	input  logic [MASK_W-1:0]  entry_mask,
	input  logic               entry_turbo,
	input  logic               poll_en,
	input  logic [PORT_W-1:0]  port,
	input  logic               held,
	input  logic [PHASE_W-1:0] repeat_gap,
	output logic [MASK_W-1:0]  contrib
);

	logic [MASK_W-1:0]  mask_q;
	logic               turbo_q;
	logic [PHASE_W-1:0] phase_q [NUM_PORTS];
	logic [NUM_PORTS-1:0] prev_q;

	logic [PHASE_W-1:0] phase_cur;
	logic [PHASE_W-1:0] phase_nxt;
	logic               fire;

	always_comb begin
		phase_cur = phase_q[port];
		phase_nxt = (phase_cur >= repeat_gap) ? '0 : phase_cur + 1'b1;
		fire = held && (mask_q != '0) &&
			(!turbo_q || !prev_q[port] || (phase_nxt == '0));
		contrib = fire ? mask_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= '0;
			turbo_q <= 1'b0;
			prev_q  <= '0;
			for (int p = 0; p < NUM_PORTS; p++)
				phase_q[p] <= '0;
		end else begin
			if (load_en) begin
				mask_q  <= entry_mask & KEY_MASK;
				turbo_q <= entry_turbo;
			end
			if (poll_en) begin
				// phase and history move even for unmapped keys
				phase_q[port] <= held ? phase_nxt : '0;
				prev_q[port]  <= held;
			end
		end
	end

endmodule

// ----- sv/gtr_merge.sv -----
// merges lane masks into the per-target accumulators and forms the result
`timescale 1ns / 1ps

module gtr_merge
	import gtr_pkg::*;
(
	input  logic                           clk,
	input  logic                           arst_n,
	input  acc_ctl_t                       ctl,
	input  logic [PORT_W-1:0]              first_port_target,
	input  logic [NUM_KEYS-1:0][MASK_W-1:0] lane_masks,
	output rsp_t                           res
);

	logic [MASK_W-1:0] accum_q [NUM_TARGETS];
	logic [MASK_W-1:0] accum_d [NUM_TARGETS];
	logic [MASK_W-1:0] lane_or;
	logic [PORT_W-1:0] target;

	always_comb begin
		target = (ctl.port == '0) ? first_port_target : ctl.port;
		lane_or = '0;
		for (int k = 0; k < NUM_KEYS; k++)
			lane_or = lane_or | lane_masks[k];
		for (int t = 0; t < NUM_TARGETS; t++)
			accum_d[t] = ctl.frame_start ? '0 : accum_q[t];
		if (ctl.port_ok)
			accum_d[target] = accum_d[target] | lane_or;
		if (ctl.load) begin
			res = '0;
		end else begin
			res.target_port = target;
			res.port_keys   = accum_d[target] & KEY_MASK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < NUM_TARGETS; t++)
				accum_q[t] <= '0;
		end else if (ctl.poll) begin
			for (int t = 0; t < NUM_TARGETS; t++)
				accum_q[t] <= accum_d[t];
		end
	end

`ifndef SYNTHESIS
	a_load_keeps_accum: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |=> ($stable(accum_q[0]) && $stable(accum_q[1]) &&
			$stable(accum_q[2]) && $stable(accum_q[3])))
		else $error("load item changed an accumulator");
	a_frame_start_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.poll && ctl.frame_start) |-> ((res.port_keys & ~lane_or) == '0))
		else $error("frame start result holds keys from an earlier poll");
`endif

endmodule

// ----- sv/gtr_top_note.sv -----
// empty unit kept beside the top level
`timescale 1ns / 1ps

// ----- sv/gamepad_turbo_remapper_core.sv -----
// top level of the gamepad turbo remapper
`timescale 1ns / 1ps
// output: a result is registered in the rsp register, or in the skid entry while rsp is stalled
// throughput: one item per cycle while req_stall is low; all 24 key lanes and the accumulator
//   merge evaluate combinationally, a two-entry output buffer absorbs rsp stalls
// reset: arst_n clears registers to their reset values, key map entries,
//   press history, turbo phases and accumulators to zero; no clearing pass
module gamepad_turbo_remapper_core
	import gtr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  req_t                  req,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output rsp_t                  rsp,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t     cfg_q;
	acc_ctl_t ctl;
	rsp_t     res;
	rsp_t     rsp_q;
	rsp_t     skid_q;
	logic     rsp_valid_q;
	logic     skid_valid_q;
	logic     accept;

	logic [NUM_KEYS-1:0]             keys;
	logic [NUM_KEYS-1:0][MASK_W-1:0] lane_masks;

	assign cfg_ready = 1'b1;
	assign req_stall = skid_valid_q;
	assign accept    = req_valid && !skid_valid_q;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.repeat_gap        <= '0;
			cfg_q.stick_mid         <= CENTER_RST;
			cfg_q.stick_dead        <= THRESH_RST;
			cfg_q.first_port_target <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_REPEAT_GAP:        cfg_q.repeat_gap        <= cfg_data;
				CFG_STICK_MID:         cfg_q.stick_mid         <= cfg_data;
				CFG_STICK_DEAD:        cfg_q.stick_dead        <= cfg_data[THR_W-1:0];
				CFG_FIRST_PORT_TARGET: cfg_q.first_port_target <= cfg_data[PORT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		ctl.port_ok     = (int'(req.port) < NUM_PORTS);
		ctl.poll        = accept && (req.func == FUNC_POLL);
		ctl.load        = req.func == FUNC_LOAD;
		ctl.frame_start = req.frame_start;
		ctl.port        = req.port;
	end

	gtr_keydec u_keydec (
		.req  (req),
		.cfg  (cfg_q),
		.keys (keys)
	);

	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
		gtr_lane u_lane (
			.clk         (clk),
			.arst_n      (arst_n),
			.load_en     (accept && (req.func == FUNC_LOAD) &&
			              (req.entry_index == IDX_W'(k))),
			.entry_mask  (req.entry_mask),
			.entry_turbo (req.entry_turbo),
			.poll_en     (ctl.poll && ctl.port_ok),
			.port        (req.port),
			.held        (keys[k]),
			.repeat_gap  (cfg_q.repeat_gap),
			.contrib     (lane_masks[k])
		);
	end

	gtr_merge u_merge (
		.clk               (clk),
		.arst_n            (arst_n),
		.ctl               (ctl),
		.first_port_target (cfg_q.first_port_target),
		.lane_masks        (lane_masks),
		.res               (res)
	);

	// output register with a skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					rsp_valid_q <= accept;
				end
			end else if (!rsp_valid_q) begin
				rsp_valid_q <= accept;
			end else if (accept) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_valid_q && !rsp_stall) begin
			rsp_q <= skid_valid_q ? skid_q : res;
		end else if (!rsp_valid_q) begin
			rsp_q <= res;
		end
		if (rsp_valid_q && rsp_stall && accept)
			skid_q <= res;
	end

`ifndef SYNTHESIS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> rsp_valid_q)
		else $error("skid entry holds an item while the output register is empty");
	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && !rsp_stall) |=> (rsp_valid_q && !skid_valid_q))
		else $error("skid entry did not move to the output register");
`endif

endmodule

// ----- tb/sv/tb_gamepad_turbo_remapper_core.sv -----
// testbench for the gamepad turbo remapper core: directed steps, then random polls and map loads
`timescale 1ns / 1ps

module tb_gamepad_turbo_remapper_core;
	import gtr_pkg::*;

	localparam int LIMIT      = 200000;
	localparam int PHASE_ITEMS = 300;
	localparam int HOLD_CYC   = 300;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_stall;
	req_t                  req = '0;
	logic                  rsp_valid;
	logic                  rsp_stall = 1'b0;
	rsp_t                  rsp;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	gamepad_turbo_remapper_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow copy of the block's registers and state
	logic [PHASE_W-1:0] cur_delay;
	logic [POS_W-1:0]   cur_center;
	logic [THR_W-1:0]   cur_thresh;
	logic [PORT_W-1:0]  cur_first;
	logic [MASK_W:0]    map_tab [NUM_KEYS];
	logic [NUM_KEYS-1:0] held_prev [NUM_PORTS];
	logic [PHASE_W-1:0] rep_phase [NUM_PORTS][NUM_KEYS];
	logic [MASK_W-1:0]  frame_keys [NUM_TARGETS];

	rsp_t want_q [$];
	int   n_fail = 0;
	int   cyc = 0;
	int   gap_pct = 0;
	int   stall_pct = 0;
	bit   hold_go = 1'b0;
	int   hold_left = 0;

	typedef struct {
		bit          is_cfg;
		cfg_idx_t    sel;
		logic [7:0]  val;
		req_t        item;
		bit          fixed;
		rsp_t        want;
	} step_t;

	step_t plan [$];

	// bit 0: below center minus threshold, bit 1: above center plus threshold
	function automatic logic [1:0] axis_dir(input logic [POS_W-1:0] pos);
		int lo;
		int hi;
		lo = int'(cur_center) - int'(cur_thresh);
		hi = int'(cur_center) + int'(cur_thresh);
		if (int'(pos) < lo)
			return 2'b01;
		if (int'(pos) > hi)
			return 2'b10;
		return 2'b00;
	endfunction

	function automatic rsp_t remap_step(input req_t r);
		rsp_t                o;
		logic [NUM_KEYS-1:0] keys;
		logic [NUM_KEYS-1:0] now;
		logic [1:0]          lx, ly, rx, ry;
		logic [PORT_W-1:0]   tgt;
		logic [PHASE_W-1:0]  nxt;
		logic [MASK_W-1:0]   m;
		o = '0;
		if (r.func == FUNC_LOAD) begin
			if (int'(r.entry_index) < NUM_KEYS)
				map_tab[r.entry_index] = {r.entry_turbo, r.entry_mask};
			return o;
		end
		if (r.frame_start) begin
			for (int t = 0; t < NUM_TARGETS; t++)
				frame_keys[t] = '0;
		end
		tgt = (r.port == '0) ? cur_first : r.port;
		if (int'(r.port) < NUM_PORTS) begin
			lx = axis_dir(r.left_x);
			ly = axis_dir(r.left_y);
			rx = axis_dir(r.right_x);
			ry = axis_dir(r.right_y);
			keys = {ry[1], rx[1], ry[0], rx[0], ly[1], lx[1], ly[0], lx[0], r.buttons};
			now = '0;
			for (int k = 0; k < NUM_KEYS; k++) begin
				if (!keys[k]) begin
					rep_phase[r.port][k] = '0;
					continue;
				end
				now[k] = 1'b1;
				nxt = (rep_phase[r.port][k] >= cur_delay) ? '0 : rep_phase[r.port][k] + 1'b1;
				rep_phase[r.port][k] = nxt;
				m = map_tab[k][MASK_W-1:0];
				if (m == '0)
					continue;
				// turbo keys fire on the first press and on each phase wrap
				if (!map_tab[k][MASK_W] || !held_prev[r.port][k] || nxt == '0)
					frame_keys[tgt] = frame_keys[tgt] | m;
			end
			held_prev[r.port] = now;
		end
		o.target_port = tgt;
		o.port_keys   = frame_keys[tgt] & KEY_MASK;
		return o;
	endfunction

	function automatic req_t poll(input logic [1:0] p, input logic fs, input logic [15:0] b,
		input logic [31:0] sticks);
		req_t r;
		r = '0;
		r.func = FUNC_POLL;
		r.port = p;
		r.frame_start = fs;
		r.buttons = b;
		{r.left_x, r.left_y, r.right_x, r.right_y} = sticks;
		return r;
	endfunction

	function automatic req_t load(input logic [4:0] idx, input logic [27:0] m, input logic t);
		req_t r;
		r = '0;
		r.func = FUNC_LOAD;
		r.entry_index = idx;
		r.entry_mask = m;
		r.entry_turbo = t;
		return r;
	endfunction

	function automatic void add_cfg(input cfg_idx_t sel, input logic [7:0] val);
		step_t s;
		s = '{default: '0, sel: sel};
		s.is_cfg = 1'b1;
		s.val = val;
		plan.push_back(s);
	endfunction

	function automatic void add_chk(input req_t r, input logic [1:0] p, input logic [27:0] k);
		step_t s;
		s = '{default: '0, sel: CFG_REPEAT_GAP};
		s.item = r;
		s.fixed = 1'b1;
		s.want.target_port = p;
		s.want.port_keys = k;
		plan.push_back(s);
	endfunction

	function automatic void add_pred(input req_t r);
		step_t s;
		s = '{default: '0, sel: CFG_REPEAT_GAP};
		s.item = r;
		plan.push_back(s);
	endfunction

	// a stick position at an edge, near the current trip points, at the center or at random
	function automatic logic [7:0] stick_pos();
		int v;
		case ($urandom_range(5))
			0: v = 0;
			1: v = 255;
			2: v = int'(cur_center) - int'(cur_thresh) - 1 + int'($urandom_range(2));
			3: v = int'(cur_center) + int'(cur_thresh) - 1 + int'($urandom_range(2));
			4: v = int'(cur_center);
			default: v = int'($urandom_range(255));
		endcase
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return v[7:0];
	endfunction

	task automatic write_reg(input cfg_idx_t sel, input logic [7:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= val;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		case (sel)
			CFG_REPEAT_GAP:        cur_delay  = val;
			CFG_STICK_MID:         cur_center = val;
			CFG_STICK_DEAD:        cur_thresh = val[THR_W-1:0];
			CFG_FIRST_PORT_TARGET: cur_first  = val[PORT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic offer_item(input req_t r, input bit fixed, input rsp_t want);
		rsp_t w;
		while ($urandom_range(99) < gap_pct) begin
			@(negedge clk);
			req_valid <= 1'b0;
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req <= r;
		do begin
			@(posedge clk);
		end while (req_stall);
		w = remap_step(r);
		want_q.push_back(fixed ? want : w);
	endtask

	task automatic wait_results();
		@(negedge clk);
		req_valid <= 1'b0;
		while (want_q.size() != 0)
			@(posedge clk);
	endtask

	// receiver: random stalls, or one long hold-off when asked
	always @(negedge clk) begin
		if (hold_go) begin
			hold_left = HOLD_CYC;
			hold_go = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		rsp_t w;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (want_q.size() == 0) begin
				$error("unexpected item: target_port %0d port_keys %07h",
					rsp.target_port, rsp.port_keys);
				n_fail++;
			end else begin
				w = want_q.pop_front();
				if (rsp.target_port !== w.target_port) begin
					$error("target_port: expected %0d, got %0d", w.target_port, rsp.target_port);
					n_fail++;
				end
				if (rsp.port_keys !== w.port_keys) begin
					$error("port_keys: expected %07h, got %07h", w.port_keys, rsp.port_keys);
					n_fail++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cyc++;
		if (cyc == LIMIT) begin
			$display("tb_gamepad_turbo_remapper_core: done, errors");
			$finish;
		end
	end

	initial begin
		logic [15:0] hold_btn [NUM_PORTS];
		logic [31:0] hold_stk [NUM_PORTS];
		logic [95:0] noise;
		req_t        r;
		int          p;
		int          a;

		cur_delay  = '0;
		cur_center = CENTER_RST;
		cur_thresh = THRESH_RST;
		cur_first  = '0;
		for (int k = 0; k < NUM_KEYS; k++)
			map_tab[k] = '0;
		for (int q = 0; q < NUM_PORTS; q++) begin
			held_prev[q] = '0;
			hold_btn[q] = '0;
			hold_stk[q] = 32'h80808080;
			for (int k = 0; k < NUM_KEYS; k++)
				rep_phase[q][k] = '0;
		end
		for (int t = 0; t < NUM_TARGETS; t++)
			frame_keys[t] = '0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		add_chk(poll(2'd0, 1'b0, 16'h0000, 32'h80808080), 2'd0, 28'h0);
		add_chk(load(5'd0, 28'hFFFFFFF, 1'b0), 2'd0, 28'h0);
		add_chk(load(5'd31, 28'hFFFFFFF, 1'b1), 2'd0, 28'h0);   // index past the table
		add_chk(load(5'd23, 28'h0000001, 1'b1), 2'd0, 28'h0);
		add_chk(load(5'd16, 28'h8000000, 1'b0), 2'd0, 28'h0);
		add_chk(poll(2'd0, 1'b1, 16'h0001, 32'h80808080), 2'd0, 28'hFFFFFFF);
		add_pred(poll(2'd1, 1'b0, 16'hFFFF, 32'h0000FFFF));
		add_pred(poll(2'd1, 1'b0, 16'hFFFF, 32'h0000FFFF));
		add_pred(poll(2'd2, 1'b1, 16'h0000, 32'h403FC0C1));     // right at the trip points
		add_chk(load(5'd1, 28'h0, 1'b1), 2'd0, 28'h0);
		add_pred(poll(2'd3, 1'b0, 16'h0002, 32'h80808080));
		add_cfg(CFG_REPEAT_GAP, 8'd3);
		repeat (5)
			add_pred(poll(2'd2, 1'b1, 16'h0000, 32'h808080FF));
		add_cfg(CFG_REPEAT_GAP, 8'd255);
		repeat (2)
			add_pred(poll(2'd2, 1'b1, 16'h0000, 32'h808080FF));
		// delay drops below the running phase: wraps and fires at once
		add_cfg(CFG_REPEAT_GAP, 8'd0);
		add_pred(poll(2'd2, 1'b1, 16'h0000, 32'h808080FF));
		add_cfg(CFG_STICK_MID, 8'd0);
		add_cfg(CFG_STICK_DEAD, 8'd127);
		add_pred(poll(2'd1, 1'b1, 16'h0000, 32'h7F80FF00));
		add_cfg(CFG_STICK_MID, 8'd255);
		add_cfg(CFG_STICK_DEAD, 8'd0);
		add_pred(poll(2'd1, 1'b1, 16'h0000, 32'hFEFF00FF));
		add_cfg(CFG_FIRST_PORT_TARGET, 8'd3);
		add_pred(poll(2'd0, 1'b0, 16'h0001, 32'h80808080));
		add_pred(poll(2'd3, 1'b0, 16'h0000, 32'hFFFFFFFF));

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				wait_results();
				write_reg(plan[i].sel, plan[i].val);
			end else begin
				offer_item(plan[i].item, plan[i].fixed, plan[i].want);
			end
		end

		for (int ph = 0; ph < 5; ph++) begin
			wait_results();
			case (ph)
				0: begin
					write_reg(CFG_REPEAT_GAP, 8'd2);
					write_reg(CFG_STICK_MID, 8'd128);
					write_reg(CFG_STICK_DEAD, 8'd64);
					write_reg(CFG_FIRST_PORT_TARGET, 8'd1);
					gap_pct = 0;
					stall_pct = 0;
				end
				1: begin
					write_reg(CFG_REPEAT_GAP, 8'd255);
					write_reg(CFG_STICK_MID, 8'd0);
					write_reg(CFG_STICK_DEAD, 8'd127);
					write_reg(CFG_FIRST_PORT_TARGET, 8'd2);
					gap_pct = 49;
					stall_pct = 0;
				end
				2: begin
					write_reg(CFG_REPEAT_GAP, 8'd0);
					write_reg(CFG_STICK_MID, 8'd255);
					write_reg(CFG_STICK_DEAD, 8'd0);
					write_reg(CFG_FIRST_PORT_TARGET, 8'd3);
					gap_pct = 0;
					stall_pct = 49;
				end
				3: begin
					write_reg(CFG_REPEAT_GAP, 8'd5);
					write_reg(CFG_STICK_MID, 8'($urandom_range(255)));
					write_reg(CFG_STICK_DEAD, 8'($urandom_range(127)));
					write_reg(CFG_FIRST_PORT_TARGET, 8'd0);
					gap_pct = 30;
					stall_pct = 30;
				end
				default: begin
					write_reg(CFG_REPEAT_GAP, 8'($urandom_range(1, 7)));
					write_reg(CFG_STICK_MID, 8'($urandom_range(255)));
					write_reg(CFG_STICK_DEAD, 8'($urandom_range(127)));
					write_reg(CFG_FIRST_PORT_TARGET, 8'($urandom_range(3)));
					gap_pct = 0;
					stall_pct = 0;
				end
			endcase

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// fill the block against a long receiver hold-off
				if (ph == 2 && n == 50)
					hold_go = 1'b1;
				if (n == PHASE_ITEMS / 2)
					wait_results();
				noise = {$urandom, $urandom, $urandom};
				r = noise[$bits(req_t)-1:0];
				if ($urandom_range(99) < 12) begin
					r.func = FUNC_LOAD;
					r.entry_index = ($urandom_range(99) < 85) ? 5'($urandom_range(23))
						: 5'($urandom_range(31, 24));
					case ($urandom_range(3))
						0: r.entry_mask = '0;
						1: r.entry_mask = 28'h1 << $urandom_range(27);
						default: r.entry_mask = 28'($urandom);
					endcase
				end else begin
					r.func = FUNC_POLL;
					p = $urandom_range(NUM_PORTS - 1);
					// keys mostly stay held across polls so turbo phases run
					if ($urandom_range(99) < 15)
						hold_btn[p] = 16'($urandom);
					else if ($urandom_range(1))
						hold_btn[p] = hold_btn[p] ^ (16'h1 << $urandom_range(15));
					if ($urandom_range(99) < 25) begin
						a = $urandom_range(3);
						hold_stk[p][a*8 +: 8] = stick_pos();
					end
					r.port = p[PORT_W-1:0];
					r.frame_start = ($urandom_range(7) == 0);
					r.buttons = hold_btn[p];
					{r.left_x, r.left_y, r.right_x, r.right_y} = hold_stk[p];
				end
				offer_item(r, 1'b0, '0);
			end
		end

		wait_results();
		repeat (4) @(posedge clk);
		if (want_q.size() != 0)
			n_fail++;
		if (n_fail == 0)
			$display("tb_gamepad_turbo_remapper_core: done, clean");
		else
			$display("tb_gamepad_turbo_remapper_core: done, errors");
		$finish;
	end

endmodule
